/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL. Empty when SYNTH is defined.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hdl/hrrd_pkg.sv */
package hrrd_pkg;

    // default size limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // raw register widths
    localparam int DIM_W  = 11;
    localparam int ROW_W  = 10;
    localparam int MLW_W  = 8;
    localparam int PIX_W  = 8;
    localparam int RUN_W  = 9;
    // internal width for clamped sizes and position compares (holds 4096)
    localparam int SIZE_W = 13;

    // reset values
    localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'(320);
    localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(240);
    localparam logic [ROW_W-1:0] RST_PREF   = '0;
    localparam logic [MLW_W-1:0] RST_MLW    = MLW_W'(5);

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH       = 2'd0,
        REG_IMAGE_HEIGHT      = 2'd1,
        REG_PREFERRED_HORIZON = 2'd2,
        REG_MIN_LINE_WIDTH    = 2'd3
    } reg_index_t;

    // outcome codes
    typedef enum logic [1:0] {
        OUTCOME_DEFAULT  = 2'd0,
        OUTCOME_TWO_LINE = 2'd1,
        OUTCOME_TOUCH    = 2'd2
    } outcome_t;

    // clamped configuration seen by the core
    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic [ROW_W-1:0]  pref;
        logic [MLW_W-1:0]  min_line;
    } cfg_t;

    // one result
    typedef struct packed {
        outcome_t          outcome;
        logic [ROW_W-1:0]  horizon_row;
    } result_t;

endpackage

/* hdl/horizon_row_run_detector.sv */
// Horizon row run detector. Takes one binary pixel per clock in raster order
// while s_tready is high (tuser marks the first pixel of a frame) and returns
// one transfer on the last pixel of each frame: the chosen horizon row and how
// it was found. The per-pixel update of the run and row counters is
// combinational, between the input register and the result register. The
// input register keeps taking pixels while a result waits on the output side;
// only the last pixel of the next frame is held until that result has been
// taken. Configuration writes are taken at any time but must only be issued
// while no pixel is in flight.
module horizon_row_run_detector #(
    parameter int MAX_WIDTH  = hrrd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hrrd_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // pixel stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] pixel
    input  logic                        s_tuser,   // [0] frame_start
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // [9:0] horizon_row, [11:10] outcome
    // configuration writes
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [hrrd_pkg::DIM_W-1:0]  cfg_data
);
    import hrrd_pkg::*;

    logic             in_valid_reg, in_valid_next;
    logic [PIX_W-1:0] pixel_reg;
    logic             fs_reg;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg;
    logic             advance;
    logic             res_valid;
    result_t          res;
    cfg_t             cfg;

    hrrd_cfg_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // core steps when a pixel is held and any result it makes has a free slot
    assign advance  = in_valid_reg && (!res_valid || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    hrrd_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .step        (advance),
        .pixel       (pixel_reg),
        .frame_start (fs_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    // handshake state
    always_comb
    begin
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance && res_valid)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && !m_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            pixel_reg <= s_tdata;
            fs_reg    <= s_tuser;
        end
        if (advance && res_valid)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.outcome, out_reg.horizon_row};

endmodule

/* hdl/hrrd_cfg_regs.sv */
module hrrd_cfg_regs #(
    parameter int MAX_WIDTH  = hrrd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hrrd_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [hrrd_pkg::DIM_W-1:0]  cfg_data,
    output hrrd_pkg::cfg_t              cfg
);
    import hrrd_pkg::*;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [ROW_W-1:0] pref_reg;
    logic [MLW_W-1:0] mlw_reg;
    logic [SIZE_W-1:0] width_ext;
    logic [SIZE_W-1:0] height_ext;

    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            pref_reg   <= RST_PREF;
            mlw_reg    <= RST_MLW;
        end
        else if (cfg_valid)
        begin
            case (reg_index_t'(cfg_index))
                REG_IMAGE_WIDTH:       width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT:      height_reg <= cfg_data;
                REG_PREFERRED_HORIZON: pref_reg   <= cfg_data[ROW_W-1:0];
                REG_MIN_LINE_WIDTH:    mlw_reg    <= cfg_data[MLW_W-1:0];
                default:               ;
            endcase
        end
    end

    // clamp sizes into the supported range
    assign width_ext  = SIZE_W'(width_reg);
    assign height_ext = SIZE_W'(height_reg);

    always_comb
    begin
        if (width_ext < SIZE_W'(3))
            cfg.width = SIZE_W'(3);
        else if (width_ext > SIZE_W'(MAX_WIDTH))
            cfg.width = SIZE_W'(MAX_WIDTH);
        else
            cfg.width = width_ext;

        if (height_ext < SIZE_W'(1))
            cfg.height = SIZE_W'(1);
        else if (height_ext > SIZE_W'(MAX_HEIGHT))
            cfg.height = SIZE_W'(MAX_HEIGHT);
        else
            cfg.height = height_ext;

        cfg.pref     = pref_reg;
        cfg.min_line = mlw_reg;
    end

endmodule

/* hdl/hrrd_core.sv */
module hrrd_core #(
    parameter int MAX_WIDTH  = hrrd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hrrd_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hrrd_pkg::cfg_t              cfg,
    input  logic                        step,
    input  logic [hrrd_pkg::PIX_W-1:0]  pixel,
    input  logic                        frame_start,
    output logic                        res_valid,
    output hrrd_pkg::result_t           res
);
    import hrrd_pkg::*;
    `include "assert_macros.svh"

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // state
    logic [CW-1:0]    col_reg,   col_next;
    logic [RW-1:0]    row_reg,   row_next;
    logic [RUN_W-1:0] len_reg,   len_next;
    logic             inrun_reg, inrun_next;
    logic             lock_reg,  lock_next;
    logic [1:0]       runs_reg,  runs_next;
    logic             tch_reg,   tch_next;
    logic [RW-1:0]    trow_reg,  trow_next;
    logic             dec_reg,   dec_next;
    logic [RW-1:0]    drow_reg,  drow_next;

    // working values
    logic [CW-1:0]    col0;
    logic [RW-1:0]    row0;
    logic [RUN_W-1:0] len0, len1, len_inc;
    logic             inrun0, inrun1;
    logic             lock0, lock1;
    logic [1:0]       runs0, runs1;
    logic             tch0, tch1;
    logic [RW-1:0]    trow0, trow1;
    logic             dec0, dec2;
    logic [RW-1:0]    drow0, drow2;
    logic             white, active, in_cols, row_end, frame_end;

    function automatic logic [RUN_W-1:0] sat_inc(input logic [RUN_W-1:0] v);
        sat_inc = (v == '1) ? v : v + RUN_W'(1);
    endfunction

    always_comb
    begin
        // frame start clears position and search state first
        col0   = frame_start ? '0   : col_reg;
        row0   = frame_start ? '0   : row_reg;
        len0   = frame_start ? '0   : len_reg;
        inrun0 = frame_start ? 1'b0 : inrun_reg;
        lock0  = frame_start ? 1'b0 : lock_reg;
        runs0  = frame_start ? '0   : runs_reg;
        tch0   = frame_start ? 1'b0 : tch_reg;
        trow0  = frame_start ? '0   : trow_reg;
        dec0   = frame_start ? 1'b0 : dec_reg;
        drow0  = frame_start ? '0   : drow_reg;

        white   = (pixel != '0);
        active  = !dec0 && (SIZE_W'(row0) >= SIZE_W'(cfg.pref));
        in_cols = (col0 != '0) && (SIZE_W'(col0) + SIZE_W'(2) <= cfg.width);

        len1    = len0;
        inrun1  = inrun0;
        lock1   = lock0;
        runs1   = runs0;
        tch1    = tch0;
        trow1   = trow0;
        len_inc = len0;

        // run tracking
        if (active && in_cols)
        begin
            if (!white)
                lock1 = 1'b0;
            if (white && !inrun0 && !lock1)
            begin
                inrun1 = 1'b1;
                len1   = sat_inc(len0);
            end
            if (white && inrun1)
            begin
                len_inc = sat_inc(len1);
                len1    = len_inc;
                if (len_inc > RUN_W'(cfg.min_line))
                begin
                    if (!tch0)
                    begin
                        tch1  = 1'b1;
                        trow1 = row0;
                    end
                    if (runs0 != 2'd3)
                        runs1 = runs0 + 2'd1;
                    lock1 = 1'b1;
                    len1  = '0;
                end
            end
            if (!white && inrun0)
            begin
                inrun1 = 1'b0;
                len1   = '0;
            end
        end

        // row and frame end
        row_end   = (SIZE_W'(col0) + SIZE_W'(1) >= cfg.width);
        frame_end = row_end && (SIZE_W'(row0) + SIZE_W'(1) >= cfg.height);

        dec2  = dec0;
        drow2 = drow0;
        if (row_end && active && runs1 > 2'd1)
        begin
            dec2  = 1'b1;
            drow2 = row0;
        end

        // result selection
        if (dec2)
        begin
            res.horizon_row = ROW_W'(drow2);
            res.outcome     = OUTCOME_TWO_LINE;
        end
        else if (tch1)
        begin
            res.horizon_row = ROW_W'(trow1);
            res.outcome     = OUTCOME_TOUCH;
        end
        else
        begin
            res.horizon_row = cfg.pref;
            res.outcome     = OUTCOME_DEFAULT;
        end
        // held pixel closes a frame; the caller qualifies it with step
        res_valid = frame_end;

        // next state
        if (frame_end)
        begin
            col_next   = '0;
            row_next   = '0;
            len_next   = '0;
            inrun_next = 1'b0;
            lock_next  = 1'b0;
            runs_next  = '0;
            tch_next   = 1'b0;
            trow_next  = '0;
            dec_next   = 1'b0;
            drow_next  = '0;
        end
        else if (row_end)
        begin
            col_next   = '0;
            row_next   = row0 + RW'(1);
            len_next   = '0;
            inrun_next = 1'b0;
            lock_next  = 1'b0;
            runs_next  = '0;
            tch_next   = tch1;
            trow_next  = trow1;
            dec_next   = dec2;
            drow_next  = drow2;
        end
        else
        begin
            col_next   = col0 + CW'(1);
            row_next   = row0;
            len_next   = len1;
            inrun_next = inrun1;
            lock_next  = lock1;
            runs_next  = runs1;
            tch_next   = tch1;
            trow_next  = trow1;
            dec_next   = dec2;
            drow_next  = drow2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            len_reg   <= '0;
            inrun_reg <= 1'b0;
            lock_reg  <= 1'b0;
            runs_reg  <= '0;
            tch_reg   <= 1'b0;
            trow_reg  <= '0;
            dec_reg   <= 1'b0;
            drow_reg  <= '0;
        end
        else if (step)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            len_reg   <= len_next;
            inrun_reg <= inrun_next;
            lock_reg  <= lock_next;
            runs_reg  <= runs_next;
            tch_reg   <= tch_next;
            trow_reg  <= trow_next;
            dec_reg   <= dec_next;
            drow_reg  <= drow_next;
        end
    end

    // a decision needs two lines, so the touch row is set too
    `ASSERT_IMPLIES(a_dec_touched, dec_reg, tch_reg, "decided without touch")
    `ASSERT_IMPLIES(a_dec_row, dec_reg, drow_reg <= row_reg, "decided row ahead of position")
    `ASSERT_IMPLIES(a_touch_row, tch_reg, trow_reg <= row_reg, "touch row ahead of position")
    `ASSERT_IMPLIES(a_run_idle, !inrun_reg, len_reg == '0, "run length left outside a run")

endmodule
